@@ hdl/mbp_pkg.sv @@
// ----------------------------------------------------------------------------
// mbp_pkg
// Shared types, constants and the sigmoid table builder for the
// backpropagation training unit.
// ----------------------------------------------------------------------------
package mbp_pkg;

  // Network shape, fixed by the transaction layout.
  localparam int unsigned N_IN     = 4;
  localparam int unsigned N_HIDDEN = 3;
  localparam int unsigned N_OUT    = 3;
  localparam int unsigned NUM_V    = (N_IN + 1) * N_HIDDEN;
  localparam int unsigned NUM_W    = (N_HIDDEN + 1) * N_OUT;

  localparam int unsigned SIG_TABLE_DEPTH = 256;
  localparam int unsigned LR_RESET        = 410;

  localparam int unsigned MAX_DIM = (N_IN > N_HIDDEN) ?
                                    ((N_IN > N_OUT) ? N_IN : N_OUT) :
                                    ((N_HIDDEN > N_OUT) ? N_HIDDEN : N_OUT);
  localparam int unsigned CNT_W   = $clog2(MAX_DIM + 1);
  localparam int unsigned X_IDX_W = $clog2(N_IN + 1);
  localparam int unsigned H_IDX_W = $clog2(N_HIDDEN + 1);
  localparam int unsigned D_IDX_W = $clog2(N_HIDDEN);
  localparam int unsigned O_IDX_W = $clog2(N_OUT);
  localparam int unsigned V_IDX_W = $clog2(NUM_V);
  localparam int unsigned W_IDX_W = $clog2(NUM_W);

  localparam int unsigned OP_W   = 32;  // multiplier operand width
  localparam int unsigned PROD_W = 64;
  localparam int unsigned ACC_W  = 48;
  localparam int unsigned ACT_W  = 13;  // unsigned Q1.12 activation
  localparam int unsigned D2_W   = 24;
  localparam int unsigned D1_W   = 28;
  localparam int unsigned LR_W   = 13;

  localparam logic [ACT_W-1:0] Q12_ONE = 13'd4096;

  localparam logic [1:0] REQ_WRITE    = 2'd0;
  localparam logic [1:0] REQ_TRAIN    = 2'd1;
  localparam logic [1:0] REQ_CLASSIFY = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [15:0] feature_0;
    logic signed [15:0] feature_1;
    logic signed [15:0] feature_2;
    logic signed [15:0] feature_3;
    logic [1:0]         target_class;
    logic [4:0]         weight_index;
    logic signed [15:0] weight_value;
  } mbp_req_t;

  typedef struct packed {
    logic [12:0] out_0;
    logic [12:0] out_1;
    logic [12:0] out_2;
    logic [1:0]  best_class;
  } mbp_rsp_t;

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic acc_load;
  } mbp_mac_ctrl_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_WRITE,
    S_HID_MUL,
    S_HID_ACC,
    S_HID_SIG,
    S_OUT_MUL,
    S_OUT_ACC,
    S_OUT_SIG,
    S_D2_MUL1,
    S_D2_MUL2,
    S_D2_ST,
    S_P_MUL,
    S_P_ACC,
    S_D1_MUL1,
    S_D1_MUL2,
    S_D1_ST,
    S_UW_MUL1,
    S_UW_MUL2,
    S_UW_ST,
    S_UV_MUL1,
    S_UV_MUL2,
    S_UV_ST,
    S_DONE
  } mbp_state_e;

  // Shift-subtract division, elaboration use only (table build).
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // One sigmoid table entry, integer arithmetic throughout.
  function automatic logic [ACT_W-1:0] sig_entry(input int unsigned idx,
                                                 input int unsigned depth);
    logic [63:0] c_off, mag, b, k, r30, term, sum, z, den, num, res;
    logic        neg;
    c_off = udiv64((64'(idx) * 64'd2 + 64'd1) * 64'd524288, 64'(depth));
    neg   = (c_off < 64'd524288);
    mag   = neg ? (64'd524288 - c_off) : (c_off - 64'd524288);
    b     = ((mag * 64'd4) * 64'd4294521974) >> 32;
    k     = udiv64(b, 64'd45426);
    r30   = (b - k * 64'd45426) << 14;
    term  = 64'd1 << 30;
    sum   = 64'd1 << 30;
    if (k >= 64'd40) begin
      z = '0;
    end else begin
      for (int n = 1; n <= 12; n++) begin
        term = udiv64((term * r30) >> 30, 64'(n));
        sum  = sum + term;
      end
      z = udiv64(64'd1 << 60, sum) >> k;
    end
    den = (64'd1 << 30) + z;
    num = neg ? (z << 12) : (64'd1 << 42);
    res = udiv64(num + (den >> 1), den);
    return res[ACT_W-1:0];
  endfunction

  // Add a rounded update to a weight, saturating to 16 bits.
  function automatic logic signed [15:0] upd_sat(input logic signed [15:0] wt,
                                                 input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] step, sum;
    step = (p + (64'sd1 <<< 35)) >>> 36;
    sum  = PROD_W'(wt) + step;
    if (sum > 64'sd32767) begin
      return 16'sh7fff;
    end else if (sum < -64'sd32768) begin
      return 16'sh8000;
    end
    return sum[15:0];
  endfunction

endpackage

@@ hdl/mbp_mac.sv @@
// ----------------------------------------------------------------------------
// mbp_mac
// Shared signed multiplier with registered product and an accumulator.
// ----------------------------------------------------------------------------
module mbp_mac (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  mbp_pkg::mbp_mac_ctrl_t                ctrl_i,
  input  logic signed [mbp_pkg::OP_W-1:0]       op_a_i,
  input  logic signed [mbp_pkg::OP_W-1:0]       op_b_i,
  output logic signed [mbp_pkg::PROD_W-1:0]     prod_o,
  output logic signed [mbp_pkg::ACC_W-1:0]      acc_o
);

  logic signed [mbp_pkg::PROD_W-1:0] prod_q;
  logic signed [mbp_pkg::ACC_W-1:0]  acc_q, acc_d;

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.acc_en) begin
      if (ctrl_i.acc_load) begin
        acc_d = prod_q[mbp_pkg::ACC_W-1:0];
      end else begin
        acc_d = acc_q + prod_q[mbp_pkg::ACC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= op_a_i * op_b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign prod_o = prod_q;
  assign acc_o  = acc_q;

endmodule

@@ hdl/mbp_sigmoid.sv @@
// ----------------------------------------------------------------------------
// mbp_sigmoid
// Sigmoid lookup: floors the Q.24 sum to Q.12, clamps, indexes the table.
// ----------------------------------------------------------------------------
module mbp_sigmoid #(
  parameter int unsigned SigDepth = mbp_pkg::SIG_TABLE_DEPTH
) (
  input  logic signed [mbp_pkg::ACC_W-1:0] acc_i,
  output logic [mbp_pkg::ACT_W-1:0]        sig_o,
  output logic [mbp_pkg::ACT_W-1:0]        bias_o
);

  localparam int unsigned TabW    = $clog2(SigDepth);
  localparam int unsigned BiasIdx = (28672 * SigDepth) >> 16;  // net = -1.0

  logic [mbp_pkg::ACT_W-1:0] tab [SigDepth];

  for (genvar g = 0; g < SigDepth; g++) begin : g_tab
    localparam logic [mbp_pkg::ACT_W-1:0] Entry = mbp_pkg::sig_entry(g, SigDepth);
    assign tab[g] = Entry;
  end

  logic signed [mbp_pkg::ACC_W-1:0] net;
  logic [15:0]                      off;
  logic [31:0]                      prod;

  always_comb begin
    net = acc_i >>> 12;
    if (net < -48'sd32768) begin
      off = 16'd0;
    end else if (net > 48'sd32767) begin
      off = 16'hffff;
    end else begin
      off = net[15:0] ^ 16'h8000;  // net + 32768
    end
    prod = 32'(off) * 32'(SigDepth);
  end

  assign sig_o  = tab[prod[16 +: TabW]];
  assign bias_o = tab[BiasIdx[TabW-1:0]];

endmodule

@@ hdl/mlp_backprop_train_infer_unit.sv @@
// ----------------------------------------------------------------------------
// mlp_backprop_train_infer_unit
// 4-3-3 sigmoid network with online backpropagation training, built
// around one shared multiply-accumulate unit under a sequencer.
// ----------------------------------------------------------------------------
//  Channel | Signals                        | Direction | Handshake
//  --------+--------------------------------+-----------+-----------------
//  request | in_valid_i/in_ready_o/in_data_i| in        | valid/ready
//  result  | out_valid_o/out_ready_i/out_..o| out       | valid/ready
//  config  | cfg_we_i/cfg_wdata_i           | in        | write, no wait
//
// Sequence: a classify runs the hidden and output passes; a write goes through
//   S_WRITE first, and training adds the delta and weight-update passes.
//   Every product goes through the single multiplier.
// One result is held in the output register; the next request transaction
//   is taken while it waits, and finishes only when the register frees.
// Reset: weights clear to zero, learning rate to 410, no sweep needed.
// ----------------------------------------------------------------------------
module mlp_backprop_train_infer_unit #(
  parameter int unsigned SigDepth = mbp_pkg::SIG_TABLE_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  mbp_pkg::mbp_req_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output mbp_pkg::mbp_rsp_t             out_data_o,
  input  logic                          cfg_we_i,
  input  logic [mbp_pkg::LR_W-1:0]      cfg_wdata_i
);

  localparam int unsigned NIn  = mbp_pkg::N_IN;
  localparam int unsigned NHid = mbp_pkg::N_HIDDEN;
  localparam int unsigned NOut = mbp_pkg::N_OUT;
  localparam int unsigned CntW = mbp_pkg::CNT_W;
  localparam int unsigned OpW  = mbp_pkg::OP_W;
  localparam int unsigned ActW = mbp_pkg::ACT_W;

  mbp_pkg::mbp_state_e state_q, state_d;
  logic [CntW-1:0]     i_q, i_d, j_q, j_d;

  mbp_pkg::mbp_req_t   req_q;
  logic [mbp_pkg::LR_W-1:0] lr_q;

  logic signed [15:0]  v_q [mbp_pkg::NUM_V];
  logic signed [15:0]  w_q [mbp_pkg::NUM_W];

  logic [ActW-1:0]     h_q  [NHid+1];
  logic [ActW-1:0]     y_q  [NOut];
  logic signed [mbp_pkg::D2_W-1:0] d2_q [NOut];
  logic signed [mbp_pkg::D1_W-1:0] d1_q [NHid];

  logic                out_valid_q;
  mbp_pkg::mbp_rsp_t   out_q;

  mbp_pkg::mbp_mac_ctrl_t             mac_ctrl;
  logic signed [OpW-1:0]              op_a, op_b;
  logic signed [mbp_pkg::PROD_W-1:0]  prod;
  logic signed [mbp_pkg::ACC_W-1:0]   acc;
  logic [ActW-1:0]                    sig_val, sig_bias;

  // Input vector with the constant -1.0 bias in front.
  logic signed [15:0] x [NIn+1];
  assign x[0] = -16'sd4096;
  assign x[1] = req_q.feature_0;
  assign x[2] = req_q.feature_1;
  assign x[3] = req_q.feature_2;
  assign x[4] = req_q.feature_3;

  // Index slices.
  logic [mbp_pkg::X_IDX_W-1:0] ix;
  logic [mbp_pkg::H_IDX_W-1:0] ih, jh;
  logic [mbp_pkg::O_IDX_W-1:0] io, jo;
  logic [mbp_pkg::D_IDX_W-1:0] jd, jdm;
  logic [CntW-1:0]             jm1;
  logic [mbp_pkg::V_IDX_W-1:0] v_addr;
  logic [mbp_pkg::W_IDX_W-1:0] w_addr_fwd, w_addr_p, w_addr_u;
  logic [ActW-1:0]             h_i, h_j;
  logic signed [ActW:0]        t_minus_y;

  assign ix   = i_q[mbp_pkg::X_IDX_W-1:0];
  assign ih   = i_q[mbp_pkg::H_IDX_W-1:0];
  assign jh   = j_q[mbp_pkg::H_IDX_W-1:0];
  assign io   = i_q[mbp_pkg::O_IDX_W-1:0];
  assign jo   = j_q[mbp_pkg::O_IDX_W-1:0];
  assign jd   = j_q[mbp_pkg::D_IDX_W-1:0];
  assign jm1  = j_q - CntW'(1);
  assign jdm  = jm1[mbp_pkg::D_IDX_W-1:0];
  assign v_addr     = mbp_pkg::V_IDX_W'(i_q * NHid + j_q);
  assign w_addr_fwd = mbp_pkg::W_IDX_W'(i_q * NOut + j_q);   // row i, column j
  assign w_addr_p   = mbp_pkg::W_IDX_W'(j_q * NOut + i_q);   // row j, column i
  assign w_addr_u   = w_addr_fwd;
  assign h_i  = (ih == '0) ? sig_bias : h_q[ih];
  assign h_j  = h_q[jh];
  assign t_minus_y = ((5'(req_q.target_class) == 5'(j_q)) ? (ActW+1)'(mbp_pkg::Q12_ONE) :
                      '0) - (ActW+1)'(y_q[jo]);

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    i_d      = i_q;
    j_d      = j_q;
    mac_ctrl = '0;
    op_a     = '0;
    op_b     = '0;
    case (state_q)
      mbp_pkg::S_IDLE: begin
        i_d = '0;
        j_d = '0;
        if (in_valid_i) begin
          state_d = (in_data_i.req_type == mbp_pkg::REQ_WRITE) ? mbp_pkg::S_WRITE :
                                                                mbp_pkg::S_HID_MUL;
        end
      end
      mbp_pkg::S_WRITE: state_d = mbp_pkg::S_HID_MUL;
      mbp_pkg::S_HID_MUL: begin
        mac_ctrl.mul_en = 1'b1;
        op_a    = OpW'(x[ix]);
        op_b    = OpW'(v_q[v_addr]);
        state_d = mbp_pkg::S_HID_ACC;
      end
      mbp_pkg::S_HID_ACC: begin
        mac_ctrl.acc_en   = 1'b1;
        mac_ctrl.acc_load = (i_q == '0);
        if (i_q == CntW'(NIn)) begin
          state_d = mbp_pkg::S_HID_SIG;
        end else begin
          i_d     = i_q + CntW'(1);
          state_d = mbp_pkg::S_HID_MUL;
        end
      end
      mbp_pkg::S_HID_SIG: begin
        i_d = '0;
        if (j_q == CntW'(NHid - 1)) begin
          j_d     = '0;
          state_d = mbp_pkg::S_OUT_MUL;
        end else begin
          j_d     = j_q + CntW'(1);
          state_d = mbp_pkg::S_HID_MUL;
        end
      end
      mbp_pkg::S_OUT_MUL: begin
        mac_ctrl.mul_en = 1'b1;
        op_a    = OpW'($signed({1'b0, h_i}));
        op_b    = OpW'(w_q[w_addr_fwd]);
        state_d = mbp_pkg::S_OUT_ACC;
      end
      mbp_pkg::S_OUT_ACC: begin
        mac_ctrl.acc_en   = 1'b1;
        mac_ctrl.acc_load = (i_q == '0);
        if (i_q == CntW'(NHid)) begin
          state_d = mbp_pkg::S_OUT_SIG;
        end else begin
          i_d     = i_q + CntW'(1);
          state_d = mbp_pkg::S_OUT_MUL;
        end
      end
      mbp_pkg::S_OUT_SIG: begin
        i_d = '0;
        if (j_q == CntW'(NOut - 1)) begin
          j_d     = '0;
          state_d = (req_q.req_type == mbp_pkg::REQ_TRAIN) ? mbp_pkg::S_D2_MUL1 :
                                                            mbp_pkg::S_DONE;
        end else begin
          j_d     = j_q + CntW'(1);
          state_d = mbp_pkg::S_OUT_MUL;
        end
      end
      // Output deltas: y(1-y) first, then times (t - y).
      mbp_pkg::S_D2_MUL1: begin
        mac_ctrl.mul_en = 1'b1;
        op_a    = OpW'($signed({1'b0, y_q[jo]}));
        op_b    = OpW'($signed({1'b0, mbp_pkg::Q12_ONE - y_q[jo]}));
        state_d = mbp_pkg::S_D2_MUL2;
      end
      mbp_pkg::S_D2_MUL2: begin
        mac_ctrl.mul_en = 1'b1;
        op_a    = OpW'(t_minus_y);
        op_b    = prod[OpW-1:0];
        state_d = mbp_pkg::S_D2_ST;
      end
      mbp_pkg::S_D2_ST: begin
        if (j_q == CntW'(NOut - 1)) begin
          i_d     = '0;
          j_d     = CntW'(1);
          state_d = mbp_pkg::S_P_MUL;
        end else begin
          j_d     = j_q + CntW'(1);
          state_d = mbp_pkg::S_D2_MUL1;
        end
      end
      // Back-propagated sum over the old output weights, hidden row j.
      mbp_pkg::S_P_MUL: begin
        mac_ctrl.mul_en = 1'b1;
        op_a    = OpW'(d2_q[io]);
        op_b    = OpW'(w_q[w_addr_p]);
        state_d = mbp_pkg::S_P_ACC;
      end
      mbp_pkg::S_P_ACC: begin
        mac_ctrl.acc_en   = 1'b1;
        mac_ctrl.acc_load = (i_q == '0);
        if (i_q == CntW'(NOut - 1)) begin
          state_d = mbp_pkg::S_D1_MUL1;
        end else begin
          i_d     = i_q + CntW'(1);
          state_d = mbp_pkg::S_P_MUL;
        end
      end
      mbp_pkg::S_D1_MUL1: begin
        mac_ctrl.mul_en = 1'b1;
        op_a    = OpW'($signed({1'b0, h_j}));
        op_b    = OpW'($signed({1'b0, mbp_pkg::Q12_ONE - h_j}));
        state_d = mbp_pkg::S_D1_MUL2;
      end
      mbp_pkg::S_D1_MUL2: begin
        mac_ctrl.mul_en = 1'b1;
        op_a    = OpW'(acc >>> 12);
        op_b    = prod[OpW-1:0];
        state_d = mbp_pkg::S_D1_ST;
      end
      mbp_pkg::S_D1_ST: begin
        i_d = '0;
        if (j_q == CntW'(NHid)) begin
          j_d     = '0;
          state_d = mbp_pkg::S_UW_MUL1;
        end else begin
          j_d     = j_q + CntW'(1);
          state_d = mbp_pkg::S_P_MUL;
        end
      end
      // Output weight update: lr*h, then times d2.
      mbp_pkg::S_UW_MUL1: begin
        mac_ctrl.mul_en = 1'b1;
        op_a    = OpW'($signed({1'b0, lr_q}));
        op_b    = OpW'($signed({1'b0, h_i}));
        state_d = mbp_pkg::S_UW_MUL2;
      end
      mbp_pkg::S_UW_MUL2: begin
        mac_ctrl.mul_en = 1'b1;
        op_a    = prod[OpW-1:0];
        op_b    = OpW'(d2_q[jo]);
        state_d = mbp_pkg::S_UW_ST;
      end
      mbp_pkg::S_UW_ST: begin
        state_d = mbp_pkg::S_UW_MUL1;
        if (j_q == CntW'(NOut - 1)) begin
          j_d = '0;
          if (i_q == CntW'(NHid)) begin
            i_d     = '0;
            state_d = mbp_pkg::S_UV_MUL1;
          end else begin
            i_d = i_q + CntW'(1);
          end
        end else begin
          j_d = j_q + CntW'(1);
        end
      end
      // Hidden weight update: lr*x, then times d1.
      mbp_pkg::S_UV_MUL1: begin
        mac_ctrl.mul_en = 1'b1;
        op_a    = OpW'($signed({1'b0, lr_q}));
        op_b    = OpW'(x[ix]);
        state_d = mbp_pkg::S_UV_MUL2;
      end
      mbp_pkg::S_UV_MUL2: begin
        mac_ctrl.mul_en = 1'b1;
        op_a    = prod[OpW-1:0];
        op_b    = OpW'(d1_q[jd]);
        state_d = mbp_pkg::S_UV_ST;
      end
      mbp_pkg::S_UV_ST: begin
        state_d = mbp_pkg::S_UV_MUL1;
        if (j_q == CntW'(NHid - 1)) begin
          j_d = '0;
          if (i_q == CntW'(NIn)) begin
            i_d     = '0;
            state_d = mbp_pkg::S_DONE;
          end else begin
            i_d = i_q + CntW'(1);
          end
        end else begin
          j_d = j_q + CntW'(1);
        end
      end
      mbp_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = mbp_pkg::S_IDLE;
        end
      end
      default: state_d = mbp_pkg::S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == mbp_pkg::S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mbp_pkg::S_IDLE;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

  // Configuration and weight store.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q <= mbp_pkg::LR_W'(mbp_pkg::LR_RESET);
      for (int k = 0; k < mbp_pkg::NUM_V; k++) v_q[k] <= '0;
      for (int k = 0; k < mbp_pkg::NUM_W; k++) w_q[k] <= '0;
    end else begin
      if (cfg_we_i) begin
        lr_q <= cfg_wdata_i;
      end
      case (state_q)
        mbp_pkg::S_WRITE: begin
          if (req_q.weight_index < 5'(mbp_pkg::NUM_V)) begin
            v_q[mbp_pkg::V_IDX_W'(req_q.weight_index)] <= req_q.weight_value;
          end else if (req_q.weight_index < 5'(mbp_pkg::NUM_V + mbp_pkg::NUM_W)) begin
            w_q[mbp_pkg::W_IDX_W'(req_q.weight_index - 5'(mbp_pkg::NUM_V))] <=
              req_q.weight_value;
          end
        end
        mbp_pkg::S_UW_ST: w_q[w_addr_u] <= mbp_pkg::upd_sat(w_q[w_addr_u], prod);
        mbp_pkg::S_UV_ST: v_q[v_addr]   <= mbp_pkg::upd_sat(v_q[v_addr], prod);
        default: ;
      endcase
    end
  end

  // Working values, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_data_i;
    end
    case (state_q)
      mbp_pkg::S_HID_SIG: begin
        h_q[0]                         <= sig_bias;
        h_q[mbp_pkg::H_IDX_W'(j_q + CntW'(1))] <= sig_val;
      end
      mbp_pkg::S_OUT_SIG: y_q[jo]  <= sig_val;
      mbp_pkg::S_D2_ST:   d2_q[jo] <= mbp_pkg::D2_W'(prod >>> 12);
      mbp_pkg::S_D1_ST:   d1_q[jdm] <= mbp_pkg::D1_W'(prod >>> 24);
      default: ;
    endcase
  end

  // Output register with first-maximum class.
  logic [1:0] best;
  always_comb begin
    best = '0;
    for (int k = 1; k < NOut; k++) begin
      if (y_q[k] > y_q[best]) best = 2'(k);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == mbp_pkg::S_DONE && (!out_valid_q || out_ready_i)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == mbp_pkg::S_DONE && (!out_valid_q || out_ready_i)) begin
      out_q.out_0      <= y_q[0];
      out_q.out_1      <= y_q[1];
      out_q.out_2      <= y_q[2];
      out_q.best_class <= best;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  mbp_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .prod_o (prod),
    .acc_o  (acc)
  );

  mbp_sigmoid #(
    .SigDepth (SigDepth)
  ) u_sig (
    .acc_i  (acc),
    .sig_o  (sig_val),
    .bias_o (sig_bias)
  );

  // Checks.
  a_accept_leaves_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q != mbp_pkg::S_IDLE)
    else $error("transaction accepted but sequencer stayed idle");

  a_done_loads_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mbp_pkg::S_DONE && state_d == mbp_pkg::S_IDLE |=> out_valid_o)
    else $error("result not presented after completion");

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    i_q <= CntW'(mbp_pkg::MAX_DIM) && j_q <= CntW'(mbp_pkg::MAX_DIM))
    else $error("loop counter out of range");

  a_out_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.out_0 <= 13'd4096 && out_data_o.out_1 <= 13'd4096 &&
                    out_data_o.out_2 <= 13'd4096 && out_data_o.best_class <= 2'd2)
    else $error("result field out of range");

  a_cfg_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> lr_q == $past(cfg_wdata_i))
    else $error("learning rate write lost");

endmodule

@@ tb/tb_mlp_backprop_train_infer_unit.sv @@
// ----------------------------------------------------------------------------
// tb_mlp_backprop_train_infer_unit
// Self-checking bench: weight writes, training steps and classifications are
// driven with random idling on both sides, and every result transaction is
// compared with a predicted network that trains in step with the block.
// ----------------------------------------------------------------------------
module tb_mlp_backprop_train_infer_unit;
  import mbp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam logic [1:0]  REQ_SPARE   = 2'd3;  // undefined code, acts as classify

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  mbp_req_t in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  mbp_rsp_t out_data_o;
  logic     cfg_we_i;
  logic [LR_W-1:0] cfg_wdata_i;

  mlp_backprop_train_infer_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // --------------------------------------------------------------------------
  // Predicted network state
  // --------------------------------------------------------------------------
  logic [12:0]  act_lut [SIG_TABLE_DEPTH];
  longint       hid_w [NUM_V];
  longint       out_w [NUM_W];
  longint       step_size;

  mbp_req_t pending_reqs [$];
  mbp_rsp_t expected_rsps [$];

  int unsigned cycle_cnt;
  int unsigned mismatch_cnt;
  int unsigned rsp_cnt;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_off_cycles;

  function automatic longint floor_shr(longint v, int s);
    if (v >= 0) return v >>> s;
    return -((-v - 1) >>> s) - 1;
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Table built independently with the same integer recipe as mbp_pkg::sig_entry.
  task automatic build_act_lut();
    longint unsigned c_off, mag, b, k, r30, term, sum, z, den, num;
    bit neg;
    for (int i = 0; i < SIG_TABLE_DEPTH; i++) begin
      c_off = ((2 * i + 1) * 64'd524288) / SIG_TABLE_DEPTH;
      neg   = c_off < 64'd524288;
      mag   = neg ? 64'd524288 - c_off : c_off - 64'd524288;
      b     = ((4 * mag) * 64'd4294521974) >> 32;
      k     = b / 45426;
      r30   = (b - k * 45426) << 14;
      term  = 64'd1 << 30;
      sum   = 64'd1 << 30;
      if (k >= 40) begin
        z = 0;
      end else begin
        for (int n = 1; n <= 12; n++) begin
          term = ((term * r30) >> 30) / n;
          sum += term;
        end
        z = ((64'd1 << 60) / sum) >> k;
      end
      den = (64'd1 << 30) + z;
      num = neg ? (z << 12) : (64'd1 << 42);
      act_lut[i] = 13'((num + den / 2) / den);
    end
  endtask

  function automatic longint squash(longint net);
    if (net < -32768) net = -32768;
    if (net > 32767) net = 32767;
    return act_lut[((net + 32768) * SIG_TABLE_DEPTH) >>> 16];
  endfunction

  // Applies one request to the predicted network and returns its result.
  function automatic mbp_rsp_t predict_net(mbp_req_t rq);
    longint x [N_IN+1];
    longint h [N_HIDDEN+1];
    longint y [N_OUT];
    longint d2 [N_OUT];
    longint d1 [N_HIDDEN+1];
    longint acc, tgt;
    int best;
    mbp_rsp_t r;
    x[0] = -4096;
    x[1] = rq.feature_0;
    x[2] = rq.feature_1;
    x[3] = rq.feature_2;
    x[4] = rq.feature_3;
    if (rq.req_type == REQ_WRITE) begin
      if (rq.weight_index < NUM_V) hid_w[rq.weight_index] = rq.weight_value;
      else if (rq.weight_index < NUM_V + NUM_W)
        out_w[rq.weight_index - NUM_V] = rq.weight_value;
    end
    h[0] = squash(-4096);
    for (int j = 0; j < N_HIDDEN; j++) begin
      acc = 0;
      for (int i = 0; i <= N_IN; i++) acc += x[i] * hid_w[i*N_HIDDEN+j];
      h[j+1] = squash(floor_shr(acc, 12));
    end
    for (int j = 0; j < N_OUT; j++) begin
      acc = 0;
      for (int i = 0; i <= N_HIDDEN; i++) acc += h[i] * out_w[i*N_OUT+j];
      y[j] = squash(floor_shr(acc, 12));
    end
    if (rq.req_type == REQ_TRAIN) begin
      // deltas use the output weights from before this step
      for (int j = 0; j < N_OUT; j++) begin
        tgt   = (j == rq.target_class) ? 4096 : 0;
        d2[j] = floor_shr((tgt - y[j]) * y[j] * (4096 - y[j]), 12);
      end
      d1[0] = 0;
      for (int i = 1; i <= N_HIDDEN; i++) begin
        acc = 0;
        for (int j = 0; j < N_OUT; j++) acc += d2[j] * out_w[i*N_OUT+j];
        acc   = floor_shr(acc, 12);
        d1[i] = floor_shr(h[i] * (4096 - h[i]) * acc, 24);
      end
      for (int i = 0; i <= N_HIDDEN; i++)
        for (int j = 0; j < N_OUT; j++)
          out_w[i*N_OUT+j] = clip16(out_w[i*N_OUT+j] +
            floor_shr(step_size * h[i] * d2[j] + (64'sd1 <<< 35), 36));
      for (int i = 0; i <= N_IN; i++)
        for (int j = 0; j < N_HIDDEN; j++)
          hid_w[i*N_HIDDEN+j] = clip16(hid_w[i*N_HIDDEN+j] +
            floor_shr(step_size * x[i] * d1[j+1] + (64'sd1 <<< 35), 36));
    end
    best = 0;
    for (int j = 1; j < N_OUT; j++) if (y[j] > y[best]) best = j;
    r.out_0 = 13'(y[0]);
    r.out_1 = 13'(y[1]);
    r.out_2 = 13'(y[2]);
    r.best_class = 2'(best);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Clock, cycle limit
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               expected_rsps.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Driver: offers queued requests at the falling edge. Prediction is made
  // at acceptance so the model runs in transaction order.
  // --------------------------------------------------------------------------
  bit req_taken;
  always @(posedge clk_i) req_taken <= rst_ni && in_valid_i && in_ready_o;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      // the front of the queue is the transaction on the bus until taken
      if (req_taken) void'(pending_reqs.pop_front());
      if (in_valid_i && !req_taken) begin
        // hold until accepted
      end else if (pending_reqs.size() != 0 &&
                   $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i  <= pending_reqs[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Predict at the accepting edge itself.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      expected_rsps.insert(expected_rsps.size(), predict_net(in_data_i));
  end

  // Receiver readiness, with a long hold-off counted here when requested.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_off_cycles != 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready_i     <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compares every result transaction with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    mbp_rsp_t exp_rsp;
    if (rst_ni && out_valid_o && out_ready_i) begin
      rsp_cnt <= rsp_cnt + 1;
      if (expected_rsps.size() == 0) begin
        mismatch_cnt = mismatch_cnt + 1;
        if (mismatch_cnt <= 10)
          $display("Unexpected result %p at cycle %0d", out_data_o, cycle_cnt);
      end else begin
        exp_rsp = expected_rsps.pop_front();
        if (out_data_o.out_0 !== exp_rsp.out_0 || out_data_o.out_1 !== exp_rsp.out_1 ||
            out_data_o.out_2 !== exp_rsp.out_2 ||
            out_data_o.best_class !== exp_rsp.best_class) begin
          mismatch_cnt = mismatch_cnt + 1;
          if (mismatch_cnt <= 10)
            $display("Mismatch at cycle %0d: exp %0d %0d %0d class %0d, got %0d %0d %0d class %0d",
                     cycle_cnt, exp_rsp.out_0, exp_rsp.out_1, exp_rsp.out_2,
                     exp_rsp.best_class, out_data_o.out_0, out_data_o.out_1,
                     out_data_o.out_2, out_data_o.best_class);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic logic signed [15:0] rnd_feature();
    case ($urandom_range(5))
      0:       return 16'($urandom);
      1:       return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: return 16'(int'($urandom_range(16384)) - 8192);
    endcase
  endfunction

  function automatic mbp_req_t rnd_req();
    mbp_req_t r;
    int unsigned pick;
    pick = $urandom_range(99);
    r.req_type     = pick < 15 ? REQ_WRITE : pick < 75 ? REQ_TRAIN :
                     pick < 95 ? REQ_CLASSIFY : REQ_SPARE;
    r.feature_0    = rnd_feature();
    r.feature_1    = rnd_feature();
    r.feature_2    = rnd_feature();
    r.feature_3    = rnd_feature();
    r.target_class = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
    r.weight_index = ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(26));
    r.weight_value = ($urandom_range(1)) ? 16'($urandom) : 16'(int'($urandom_range(8192)) - 4096);
    return r;
  endfunction

  task automatic queue_req(logic [1:0] kind, logic signed [15:0] f, logic [1:0] tc,
                           logic [4:0] idx, logic signed [15:0] wv);
    mbp_req_t r;
    r = '{kind, f, -f, f >>> 1, 16'sd4096, tc, idx, wv};
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  // Waits until every result has arrived, then lets the pipe drain.
  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid_i || expected_rsps.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_step(logic [LR_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    step_size = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_phase(int n, int unsigned idle, int unsigned stall);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) pending_reqs.insert(pending_reqs.size(), rnd_req());
    drain();
  endtask

  initial begin
    rst_ni = 1'b0; in_valid_i = 1'b0; in_data_i = '0; out_ready_i = 1'b0;
    cfg_we_i = 1'b0; cfg_wdata_i = '0;
    cycle_cnt = 0; mismatch_cnt = 0; rsp_cnt = 0; hold_off_cycles = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    build_act_lut();
    foreach (hid_w[i]) hid_w[i] = 0;
    foreach (out_w[i]) out_w[i] = 0;
    step_size = LR_RESET;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: zero network, weight extremes, every request kind, odd cases.
    queue_req(REQ_CLASSIFY, 16'sd0, 2'd0, 5'd0, 16'sd0);
    queue_req(REQ_WRITE, 16'sh7fff, 2'd0, 5'd0, 16'sh7fff);
    queue_req(REQ_WRITE, 16'sh8000, 2'd0, 5'd14, 16'sh8000);
    queue_req(REQ_WRITE, 16'sd4096, 2'd0, 5'd15, 16'sd8192);
    queue_req(REQ_WRITE, 16'sd4096, 2'd0, 5'd26, -16'sd8192);
    queue_req(REQ_WRITE, 16'sd100, 2'd0, 5'd27, 16'sh7fff);  // out of range index
    queue_req(REQ_WRITE, 16'sd100, 2'd0, 5'd31, 16'sh8000);
    queue_req(REQ_TRAIN, 16'sd4096, 2'd0, 5'd0, 16'sd0);
    queue_req(REQ_TRAIN, -16'sd4096, 2'd1, 5'd0, 16'sd0);
    queue_req(REQ_TRAIN, 16'sh7fff, 2'd2, 5'd0, 16'sd0);
    queue_req(REQ_TRAIN, 16'sh8000, 2'd3, 5'd0, 16'sd0);      // no target
    queue_req(REQ_SPARE, 16'sd2048, 2'd0, 5'd0, 16'sd0);      // undefined kind
    queue_req(REQ_CLASSIFY, 16'sh7fff, 2'd0, 5'd0, 16'sd0);
    queue_req(REQ_CLASSIFY, 16'sh8000, 2'd0, 5'd0, 16'sd0);
    drain();
    set_step(13'd4096);
    for (int i = 0; i < 6; i++) queue_req(REQ_TRAIN, 16'sh7fff, 2'(i % 3), 5'd0, 16'sd0);
    drain();
    set_step(13'h1fff);   // above one, used as given
    for (int i = 0; i < 4; i++) queue_req(REQ_TRAIN, -16'sd8192, 2'(i % 3), 5'd0, 16'sd0);
    drain();
    set_step(13'd0);

    random_phase(150, 0, 0);
    set_step(LR_W'(LR_RESET));
    random_phase(300, 45, 0);
    set_step(13'($urandom_range(4096)));
    random_phase(300, 0, 45);

    // Long receiver hold-off while the sender keeps offering.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(negedge clk_i);
    hold_off_cycles <= 2000;
    for (int i = 0; i < 20; i++) pending_reqs.insert(pending_reqs.size(), rnd_req());
    drain();

    set_step(13'd1);
    random_phase(300, 34, 34);
    set_step(13'd600);
    random_phase(250, 45, 45);

    $display("Covered %0d results (%0d mismatches) over idle/stall mixes, step sizes 0..8191,",
             rsp_cnt, mismatch_cnt);
    $display("weight writes incl. out-of-range indices, training and classify transactions.");
    if (mismatch_cnt == 0 && expected_rsps.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ mlp_backprop_train_infer_unit.f @@
hdl/mbp_pkg.sv
hdl/mbp_mac.sv
hdl/mbp_sigmoid.sv
hdl/mlp_backprop_train_infer_unit.sv
tb/tb_mlp_backprop_train_infer_unit.sv
